/* hdl/bf3_pkg.sv */
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Sizes, register decode, queue geometry and the reciprocal used for the
// division by nine.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int PIX_W    = 8;

  localparam logic [WIDTH_W-1:0]  MIN_SIZE_W = WIDTH_W'(3);
  localparam logic [HEIGHT_W-1:0] MIN_SIZE_H = HEIGHT_W'(3);
  localparam logic [WIDTH_W-1:0]  MAX_SIZE_W = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] MAX_SIZE_H = HEIGHT_W'(MAX_HEIGHT);

  localparam int ADDR_W = 3;
  localparam logic REG_PADDED_WIDTH  = 1'b0;
  localparam logic REG_PADDED_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             emit;
    logic             row_end;
    logic             frame_end;
  } bf3_item_t;

endpackage

/* hdl/bf3_front.sv */
// ----------------------------------------------------------------------------
// bf3_front: position tracking and line stores
// Counts columns and rows, reads the two stored rows above each pixel and
// writes the updated column back in the next cycle, then hands the item on.
// ----------------------------------------------------------------------------
module bf3_front
  import bf3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [WIDTH_W-1:0]  padded_width,
  input  logic [HEIGHT_W-1:0] padded_height,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    pixel_in,
  input  logic [QCOUNT_W-1:0] queue_count,
  output logic                push,
  output bf3_item_t           push_item
);

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic                accept;
  logic                last_col;
  logic                last_row;

  logic             s1_valid;
  logic [COL_W-1:0] s1_addr;
  logic [PIX_W-1:0] s1_bot;
  logic             s1_emit;
  logic             s1_row_end;
  logic             s1_frame_end;

  always_comb begin
    priority if (padded_width < MIN_SIZE_W) begin
      width_eff = MIN_SIZE_W;
    end else if (padded_width > MAX_SIZE_W) begin
      width_eff = MAX_SIZE_W;
    end else begin
      width_eff = padded_width;
    end
    priority if (padded_height < MIN_SIZE_H) begin
      height_eff = MIN_SIZE_H;
    end else if (padded_height > MAX_SIZE_H) begin
      height_eff = MAX_SIZE_H;
    end else begin
      height_eff = padded_height;
    end
  end

  assign in_ready = ({1'b0, queue_count} + (QCOUNT_W+1)'(s1_valid)) < (QCOUNT_W+1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign last_col = (WIDTH_W'(column_count) + WIDTH_W'(1)) >= width_eff;
  assign last_row = (HEIGHT_W'(row_count) + HEIGHT_W'(1)) >= height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= column_count;
      s1_bot       <= pixel_in;
      s1_emit      <= (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));
      s1_row_end   <= last_col;
      s1_frame_end <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[column_count];
    end
    if (s1_valid) begin
      line_mem[s1_addr] <= {rd_data[PIX_W-1:0], s1_bot};
    end
  end

  assign push                = s1_valid;
  assign push_item.top       = rd_data[2*PIX_W-1:PIX_W];
  assign push_item.mid       = rd_data[PIX_W-1:0];
  assign push_item.bot       = s1_bot;
  assign push_item.emit      = s1_emit;
  assign push_item.row_end   = s1_row_end;
  assign push_item.frame_end = s1_frame_end;

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> (s1_addr != column_count))
    else $error("Line store read collides with pending write.");

  a_push_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> push)
    else $error("Accepted item was not forwarded.");
`endif

endmodule

/* hdl/bf3_queue.sv */
// ----------------------------------------------------------------------------
// bf3_queue: short item queue between front and back
// A small register queue that lets the line store side and the arithmetic
// side stall independently.
// ----------------------------------------------------------------------------
module bf3_queue
  import bf3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bf3_item_t           push_item,
  input  logic                pop,
  output logic                not_empty,
  output bf3_item_t           head,
  output logic [QCOUNT_W-1:0] count
);

  bf3_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !do_pop && (count == QCOUNT_W'(QUEUE_DEPTH))))
    else $error("Queue written while full.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("Queue count out of range.");
`endif

endmodule

/* hdl/bf3_back.sv */
// ----------------------------------------------------------------------------
// bf3_back: window, sum and division by nine
// Shifts each item's column into the 3x3 window, sums the nine pixels and
// divides by nine through a reciprocal multiply into the output register.
// ----------------------------------------------------------------------------
module bf3_back
  import bf3_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  bf3_item_t        head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] mean_out,
  output logic             row_end,
  output logic             frame_end
);

  logic [PIX_W-1:0]  window [6];
  logic [SUM_W-1:0]  window_sum;
  logic [PROD_W-1:0] product;

  logic             a_valid;
  logic [SUM_W-1:0] a_sum;
  logic             a_row_end;
  logic             a_frame_end;
  logic             a_adv;
  logic             b_adv;

  assign b_adv = !out_valid || out_ready;
  assign a_adv = !a_valid || b_adv;
  assign pop   = not_empty && a_adv;

  always_comb begin
    window_sum = SUM_W'(head.top) + SUM_W'(head.mid) + SUM_W'(head.bot);
    for (int k = 0; k < 6; k++) begin
      window_sum = window_sum + SUM_W'(window[k]);
    end
  end

  assign product = PROD_W'(a_sum) * PROD_W'(RECIP_NINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        window[k] <= '0;
      end
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        window[0] <= window[3];
        window[1] <= window[4];
        window[2] <= window[5];
        window[3] <= head.top;
        window[4] <= head.mid;
        window[5] <= head.bot;
      end
      if (a_adv) begin
        a_valid <= pop && head.emit;
      end
      if (b_adv) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_sum       <= window_sum;
      a_row_end   <= head.row_end;
      a_frame_end <= head.frame_end;
    end
    if (b_adv && a_valid) begin
      mean_out  <= product[RECIP_SHIFT +: PIX_W];
      row_end   <= a_row_end;
      frame_end <= a_frame_end;
    end
  end

endmodule

/* hdl/box_filter_3x3_unit.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_unit: streaming 3x3 mean filter over a padded 8-bit image
// Takes padded pixels in raster order and returns the truncated mean of each
// full 3x3 neighborhood with end-of-row and end-of-frame marks.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_ready   pixel_in
//   output   out_valid/out_ready mean_out, row_end, frame_end
//   config   APB write/read      padded_width (0x0), padded_height (0x4)
//
// One pixel is accepted per clock while in_ready is high; a result is offered
// after the line store read, queue write, sum register and output register.
// The line store is a single memory of 1024 entries of two pixels, read at
// accept and written back the following cycle.
// Reset clears counters, window and queue; the line store needs no clearing.
// A stalled output drops input ready once queue and read stage hold four items.
// ----------------------------------------------------------------------------
module box_filter_3x3_unit
  import bf3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  mean_out,
  output logic              row_end,
  output logic              frame_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [WIDTH_W-1:0]  padded_width;
  logic [HEIGHT_W-1:0] padded_height;
  logic                cfg_write;

  logic                push;
  bf3_item_t           push_item;
  logic                pop;
  logic                not_empty;
  bf3_item_t           head;
  logic [QCOUNT_W-1:0] queue_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width  <= WIDTH_W'(770);
      padded_height <= HEIGHT_W'(770);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PADDED_WIDTH: padded_width <= pwdata[WIDTH_W-1:0];
        REG_PADDED_HEIGHT: padded_height <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PADDED_WIDTH: prdata = 32'(padded_width);
      REG_PADDED_HEIGHT: prdata = 32'(padded_height);
      default: prdata = '0;
    endcase
  end

  bf3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .padded_width  (padded_width),
    .padded_height (padded_height),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_in      (pixel_in),
    .queue_count   (queue_count),
    .push          (push),
    .push_item     (push_item)
  );

  bf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (queue_count)
  );

  bf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean_out  (mean_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule

/* test/box_filter_3x3_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_3x3_unit_test: self-checking bench for the 3x3 mean filter
// Streams padded frames through the pixel channel and checks every mean,
// end-of-row and end-of-frame mark against a line-buffer model kept here.
// It covers extreme pixels, clamped and extreme frame sizes, resizing in the
// middle of a frame, and random frames. Both channels idle at random.
// ----------------------------------------------------------------------------
module box_filter_3x3_unit_test;
  import bf3_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 600;
  localparam int CALM_PIXELS   = 200;

  typedef enum int {
    PIX_RANDOM,
    PIX_ZERO,
    PIX_FULL,
    PIX_EXTREME,
    PIX_MIXED
  } pixel_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             row_end;
    logic             frame_end;
  } box_mean_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [PIX_W-1:0]  mean_out;
  logic              row_end;
  logic              frame_end;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Model state: the two rows above, the two previous window columns,
  // the raster position and the size registers.
  logic [PIX_W-1:0]    line_two_up [MAX_WIDTH];
  logic [PIX_W-1:0]    line_one_up [MAX_WIDTH];
  logic [PIX_W-1:0]    window_cols [6];
  logic [COL_W-1:0]    col_pos;
  logic [ROW_W-1:0]    row_pos;
  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;

  box_mean_t mean_q[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        pixels_sent = 0;
  bit        idle_on = 1'b1;

  box_filter_3x3_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean_out  (mean_out),
    .row_end   (row_end),
    .frame_end (frame_end),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void reset_filter_model();
    for (int k = 0; k < 6; k++) window_cols[k] = '0;
    col_pos    = '0;
    row_pos    = '0;
    cfg_width  = WIDTH_W'(770);
    cfg_height = HEIGHT_W'(770);
  endfunction

  // Advances the model by one accepted pixel and queues the mean it causes.
  function automatic void advance_filter(input logic [PIX_W-1:0] px);
    int               w;
    int               h;
    int               c;
    int               total;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             last_col;
    logic             last_row;
    box_mean_t        res;
    w = int'(cfg_width);
    if (w < int'(MIN_SIZE_W)) w = int'(MIN_SIZE_W);
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(cfg_height);
    if (h < int'(MIN_SIZE_H)) h = int'(MIN_SIZE_H);
    else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    c = int'(col_pos);
    if (c >= MAX_WIDTH) c = 0;
    top = line_two_up[c];
    mid = line_one_up[c];
    line_two_up[c] = mid;
    line_one_up[c] = px;
    total = int'(top) + int'(mid) + int'(px);
    for (int k = 0; k < 6; k++) total += int'(window_cols[k]);
    last_col = (c + 1 >= w);
    last_row = (int'(row_pos) + 1 >= h);
    if (row_pos >= 2 && c >= 2) begin
      res.mean      = PIX_W'(total / 9);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      mean_q.push_back(res);
    end
    window_cols[0] = window_cols[3];
    window_cols[1] = window_cols[4];
    window_cols[2] = window_cols[5];
    window_cols[3] = top;
    window_cols[4] = mid;
    window_cols[5] = px;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = COL_W'(c + 1);
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mode_t mode);
    unique case (mode)
      PIX_ZERO: begin
        return '0;
      end
      PIX_FULL: begin
        return '1;
      end
      PIX_EXTREME: begin
        return $urandom_range(0, 1) ? '1 : '0;
      end
      PIX_MIXED: begin
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
        return PIX_W'($urandom_range(0, 255));
      end
      default: begin
        return PIX_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_filter(px);
    pixels_sent++;
  endtask

  // Sends pixels until the raster position wraps to the start of a frame.
  task automatic send_frame(input pixel_mode_t mode);
    do begin
      if (idle_on && $urandom_range(0, 199) == 0) wait_drained();
      send_pixel(pick_pixel(mode));
    end while (col_pos != '0 || row_pos != '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Runs setup and access phases and leaves psel high for a following access.
  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] value,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    logic [31:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rdata !== want)
      report_mismatch($sformatf("register %0d reads 0x%0h, want 0x%0h", idx, rdata, want));
  endtask

  task automatic program_reg(input logic idx, input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, idx, value, rdata);
    if (idx == REG_PADDED_WIDTH) begin
      cfg_width = value[WIDTH_W-1:0];
      check_reg(idx, 32'(cfg_width));
    end else begin
      cfg_height = value[HEIGHT_W-1:0];
      check_reg(idx, 32'(cfg_height));
    end
  endtask

  task automatic set_size(input int w, input int h);
    wait_drained();
    program_reg(REG_PADDED_WIDTH, ($urandom() & ~32'h7FF) | 32'(w));
    program_reg(REG_PADDED_HEIGHT, ($urandom() & ~32'h1FFF) | 32'(h));
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    box_mean_t want;
    if (!rst && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result mean %0d", mean_out));
      end else begin
        want = mean_q.pop_front();
        if (mean_out !== want.mean)
          report_mismatch($sformatf("mean %0d, want %0d", mean_out, want.mean));
        if (row_end !== want.row_end)
          report_mismatch($sformatf("row_end %b, want %b", row_end, want.row_end));
        if (frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b", frame_end, want.frame_end));
      end
    end
  end

  task automatic test_register_reset();
    check_reg(REG_PADDED_WIDTH, 32'd770);
    check_reg(REG_PADDED_HEIGHT, 32'd770);
  endtask

  task automatic test_pixel_extremes();
    set_size(3, 3);
    send_frame(PIX_ZERO);
    send_frame(PIX_FULL);
    set_size(4, 3);
    send_frame(PIX_EXTREME);
  endtask

  // Sizes below three behave as three.
  task automatic test_small_size_clamp();
    set_size(0, 1);
    send_frame(PIX_MIXED);
    set_size(2, 2);
    send_frame(PIX_MIXED);
    set_size(1, 0);
    send_frame(PIX_RANDOM);
  endtask

  // Shrinking a size mid-frame wraps a counter that is already past the end.
  task automatic test_resize_mid_frame();
    set_size(8, 8);
    while (row_pos != 3 || col_pos != 6) send_pixel(pick_pixel(PIX_RANDOM));
    wait_drained();
    program_reg(REG_PADDED_WIDTH, 32'd4);
    send_frame(PIX_RANDOM);
    set_size(6, 10);
    while (row_pos != 5 || col_pos != 2) send_pixel(pick_pixel(PIX_RANDOM));
    wait_drained();
    program_reg(REG_PADDED_HEIGHT, 32'd3);
    send_frame(PIX_RANDOM);
  endtask

  // Largest sizes, written above the clamp: one full row, then both sizes
  // shrink so that the frame ends after two short rows.
  task automatic test_size_extremes();
    set_size(2047, 8191);
    while (row_pos != 1) send_pixel(pick_pixel(PIX_MIXED));
    wait_drained();
    program_reg(REG_PADDED_WIDTH, 32'd3);
    program_reg(REG_PADDED_HEIGHT, 32'd3);
    send_frame(PIX_MIXED);
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int pick;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      idle_on = (pixels_sent - start < RANDOM_PIXELS - CALM_PIXELS) &&
                ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) w = $urandom_range(0, 2);
      else if (pick == 1) w = $urandom_range(17, 48);
      else w = $urandom_range(3, 16);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      set_size(w, h);
      repeat ($urandom_range(1, 3)) send_frame(PIX_MIXED);
    end
    idle_on = 1'b0;
  endtask

  initial begin
    reset_filter_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_pixel_extremes();
    test_small_size_clamp();
    test_resize_mid_frame();
    test_size_extremes();
    test_random_frames();
    wait_drained();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
